// File: src/srpg_pkg.sv
// srpg_pkg: shared types, codes and the microcode table of the stepper ramp
// period generator. Used by srpg_datapath and stepper_ramp_period_generator.
// No dependencies.
`default_nettype none
package srpg_pkg;

	localparam int UPC_W = 5;
	localparam logic [UPC_W-1:0] UPC_FIN = 5'd21;

	localparam int F_W   = 98;   // factor 1 +/- q + 1.5q^2, 32.32 plus headroom
	localparam int ACC_W = 128;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_UP    = 3'd1,
		PH_CRUISE = 3'd2,
		PH_DOWN  = 3'd3,
		PH_END   = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		MS_NONE,
		MS_PP,
		MS_M0P0,
		MS_M0P1,
		MS_M1P0,
		MS_M1P1,
		MS_Q00,
		MS_Q01,
		MS_Q11,
		MS_PF0,
		MS_PF1
	} mul_sel_t;

	typedef enum logic [2:0] {
		AC_NONE,
		AC_LOAD0,
		AC_ADD32,
		AC_ADD33,
		AC_ADD64
	} acc_op_t;

	typedef enum logic [2:0] {
		MV_NONE,
		MV_P2,
		MV_Q,
		MV_F1,
		MV_F2,
		MV_F3,
		MV_R
	} mv_t;

	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_JMP_FIXED,
		SQ_FIN
	} seq_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		mv_t      mv;
		seq_t     seq;
	} ucw_t;

	localparam ucw_t UCW_NOP = '{mul_sel: MS_NONE, acc_op: AC_NONE, mv: MV_NONE, seq: SQ_FIN};

	function automatic ucw_t mk(mul_sel_t ms, acc_op_t ac, mv_t mv, seq_t sq);
		ucw_t w;
		w.mul_sel = ms;
		w.acc_op  = ac;
		w.mv      = mv;
		w.seq     = sq;
		return w;
	endfunction

	// product of a step is in the product register at the next step,
	// a move sees the accumulator of the step before
	function automatic ucw_t ucode(logic [UPC_W-1:0] upc);
		ucw_t w;
		case (upc)
			5'd0:  w = mk(MS_NONE, AC_NONE,  MV_NONE, SQ_JMP_FIXED);
			5'd1:  w = mk(MS_PP,   AC_NONE,  MV_NONE, SQ_NEXT);
			5'd2:  w = mk(MS_NONE, AC_LOAD0, MV_NONE, SQ_NEXT);
			5'd3:  w = mk(MS_NONE, AC_NONE,  MV_P2,   SQ_NEXT);
			5'd4:  w = mk(MS_M0P0, AC_NONE,  MV_NONE, SQ_NEXT);
			5'd5:  w = mk(MS_M0P1, AC_LOAD0, MV_NONE, SQ_NEXT);
			5'd6:  w = mk(MS_M1P0, AC_ADD32, MV_NONE, SQ_NEXT);
			5'd7:  w = mk(MS_M1P1, AC_ADD32, MV_NONE, SQ_NEXT);
			5'd8:  w = mk(MS_NONE, AC_ADD64, MV_NONE, SQ_NEXT);
			5'd9:  w = mk(MS_NONE, AC_NONE,  MV_Q,    SQ_NEXT);
			5'd10: w = mk(MS_Q00,  AC_NONE,  MV_NONE, SQ_NEXT);
			5'd11: w = mk(MS_Q01,  AC_LOAD0, MV_NONE, SQ_NEXT);
			5'd12: w = mk(MS_Q11,  AC_ADD33, MV_NONE, SQ_NEXT);
			5'd13: w = mk(MS_NONE, AC_ADD64, MV_NONE, SQ_NEXT);
			5'd14: w = mk(MS_NONE, AC_NONE,  MV_F1,   SQ_NEXT);
			5'd15: w = mk(MS_NONE, AC_NONE,  MV_F2,   SQ_NEXT);
			5'd16: w = mk(MS_NONE, AC_NONE,  MV_F3,   SQ_NEXT);
			5'd17: w = mk(MS_PF0,  AC_NONE,  MV_NONE, SQ_NEXT);
			5'd18: w = mk(MS_PF1,  AC_LOAD0, MV_NONE, SQ_NEXT);
			5'd19: w = mk(MS_NONE, AC_ADD32, MV_NONE, SQ_NEXT);
			5'd20: w = mk(MS_NONE, AC_NONE,  MV_R,    SQ_NEXT);
			5'd21: w = mk(MS_NONE, AC_NONE,  MV_NONE, SQ_FIN);
			default: w = UCW_NOP;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: src/srpg_datapath.sv
// srpg_datapath: shared 32x32 multiplier, 128-bit accumulator and the
// working registers of the ramp recurrence, driven by microcode words.
// Depends on srpg_pkg.
`default_nettype none
module srpg_datapath (
	input  wire logic              clk,
	input  wire srpg_pkg::ucw_t    ctrl,
	input  wire logic              ramp_up,
	input  wire logic [31:0]       period,
	input  wire logic [55:0]       accel_m,
	output logic      [31:0]       ramp_val
);
	import srpg_pkg::*;

	logic [31:0]      mul_a, mul_b;
	logic [63:0]      prod_q;
	logic [ACC_W-1:0] acc_q;
	logic [63:0]      p2_q;
	logic [63:0]      q_q;
	logic [F_W-1:0]   f_q;
	logic [31:0]      r_q;
	logic [31:0]      m1;
	logic [F_W:0]     f_diff;
	logic [31:0]      r_next;

	assign m1 = {8'b0, accel_m[55:32]};

	always_comb begin
		case (ctrl.mul_sel)
			MS_PP:   begin mul_a = period;         mul_b = period;       end
			MS_M0P0: begin mul_a = accel_m[31:0];  mul_b = p2_q[31:0];   end
			MS_M0P1: begin mul_a = accel_m[31:0];  mul_b = p2_q[63:32];  end
			MS_M1P0: begin mul_a = m1;             mul_b = p2_q[31:0];   end
			MS_M1P1: begin mul_a = m1;             mul_b = p2_q[63:32];  end
			MS_Q00:  begin mul_a = q_q[31:0];      mul_b = q_q[31:0];    end
			MS_Q01:  begin mul_a = q_q[31:0];      mul_b = q_q[63:32];   end
			MS_Q11:  begin mul_a = q_q[63:32];     mul_b = q_q[63:32];   end
			MS_PF0:  begin mul_a = period;         mul_b = f_q[31:0];    end
			MS_PF1:  begin mul_a = period;         mul_b = f_q[63:32];   end
			default: begin mul_a = '0;             mul_b = '0;           end
		endcase
	end

	// ramp up subtracts q, floored at zero
	assign f_diff = {1'b0, f_q} - {35'b0, q_q};

	always_comb begin
		if (period == '0) begin
			r_next = '0;
		end else if (f_q[F_W-1:64] != '0 || acc_q[95:64] != '0) begin
			r_next = '1;
		end else begin
			r_next = acc_q[63:32];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_sel != MS_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		case (ctrl.acc_op)
			AC_LOAD0: acc_q <= {64'b0, prod_q};
			AC_ADD32: acc_q <= acc_q + {32'b0, prod_q, 32'b0};
			AC_ADD33: acc_q <= acc_q + {31'b0, prod_q, 33'b0};
			AC_ADD64: acc_q <= acc_q + {prod_q, 64'b0};
			default: ;
		endcase
		case (ctrl.mv)
			MV_P2: p2_q <= acc_q[63:0];
			MV_Q:  q_q  <= acc_q[119:56];
			// q^2 >> 32 plus half of it
			MV_F1: f_q  <= {2'b0, acc_q[127:32]} + {3'b0, acc_q[127:33]};
			MV_F2: f_q  <= f_q + {{(F_W-33){1'b0}}, 1'b1, 32'b0};
			MV_F3: begin
				if (ramp_up) begin
					f_q <= f_diff[F_W] ? '0 : f_diff[F_W-1:0];
				end else begin
					f_q <= f_q + {34'b0, q_q};
				end
			end
			MV_R:  r_q  <= r_next;
			default: ;
		endcase
	end

	assign ramp_val = r_q;

endmodule
`default_nettype wire

// File: src/stepper_ramp_period_generator.sv
// stepper_ramp_period_generator: top level with the microcode sequencer,
// move state, configuration registers and output register.
// Depends on srpg_pkg and srpg_datapath.
//
//  channel  | direction | signals                         | payload
//  ---------+-----------+---------------------------------+---------------------------------
//  s_axis   | in        | s_tvalid s_tready s_tdata s_tuser | tdata step_count, tuser action
//  m_axis   | out       | m_tvalid m_tready m_tdata m_tlast | tdata period_us, phase; tlast done
//  config   | in        | cfg_we cfg_index cfg_data       | register write, no wait
//
// a ramp request runs 22 sequencer steps (at most one shared 32x32 multiply per
// step, 10 multiplies into a 128-bit accumulator); begin, start, cruise and end
// requests run 2 steps. the result is registered at the edge that ends the last
// step and the next request can be taken in the cycle after.
// one request is in work at a time; the last step waits while the output
// register is full and not taken. reset loads defaults and clears the move.
`default_nettype none
module stepper_ramp_period_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] step_count
	input  wire logic        s_tuser,   // [0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [15:0] period_us, [18:16] phase, zero pad
	output logic             m_tlast,   // done_res
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [55:0] cfg_data
);
	import srpg_pkg::*;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_TARGET = 2'd1;
	localparam logic [1:0] REG_ACCEL  = 2'd2;
	localparam logic [1:0] REG_DIST   = 2'd3;

	logic [15:0]      base_q, target_q;
	logic [55:0]      accel_m_q;
	logic [31:0]      accel_dist_q;

	logic [31:0]      steps_done_q, total_q, period_q;
	logic             busy_q;
	logic [UPC_W-1:0] upc_q, upc_next;
	logic             begin_q;
	logic [31:0]      count_q;
	phase_t           phase_q, phase_cls;
	logic             out_valid_q;
	logic [15:0]      out_period_q;
	phase_t           out_phase_q;
	logic             out_last_q;

	ucw_t             ctrl;
	logic [31:0]      ramp_val;
	logic             accept, fixed_path, fin_go;
	logic [31:0]      lo_bound, hi_bound, np;
	logic [31:0]      steps_new;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign ctrl     = busy_q ? ucode(upc_q) : UCW_NOP;

	always_comb begin
		if (steps_done_q == '0) begin
			phase_cls = PH_START;
		end else if (steps_done_q >= total_q) begin
			phase_cls = PH_END;
		end else if (steps_done_q <= accel_dist_q) begin
			phase_cls = PH_UP;
		end else if (total_q - steps_done_q <= accel_dist_q) begin
			phase_cls = PH_DOWN;
		end else begin
			phase_cls = PH_CRUISE;
		end
	end

	assign fixed_path = begin_q || !(phase_q inside {PH_UP, PH_DOWN});
	assign fin_go     = busy_q && ctrl.seq == SQ_FIN && (!out_valid_q || m_tready);

	always_comb begin
		case (ctrl.seq)
			SQ_JMP_FIXED: upc_next = fixed_path ? UPC_FIN : upc_q + 1'b1;
			SQ_NEXT:      upc_next = upc_q + 1'b1;
			default:      upc_next = upc_q;
		endcase
	end

	assign lo_bound = {target_q, 16'b0};
	assign hi_bound = {base_q, 16'b0};

	always_comb begin
		case (phase_q)
			PH_CRUISE: np = lo_bound;
			PH_UP, PH_DOWN: begin
				if (ramp_val < lo_bound) begin
					np = lo_bound;
				end else if (ramp_val > hi_bound) begin
					np = hi_bound;
				end else begin
					np = ramp_val;
				end
			end
			default: np = hi_bound;
		endcase
	end

	assign steps_new = (steps_done_q < total_q) ? steps_done_q + 32'd1 : steps_done_q;

	srpg_datapath u_dp (
		.clk      (clk),
		.ctrl     (ctrl),
		.ramp_up  (phase_q == PH_UP),
		.period   (period_q),
		.accel_m  (accel_m_q),
		.ramp_val (ramp_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= 16'hFFFF;
			target_q     <= 16'd1000;
			accel_m_q    <= '0;
			accel_dist_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:   base_q       <= cfg_data[15:0];
				REG_TARGET: target_q     <= cfg_data[15:0];
				REG_ACCEL:  accel_m_q    <= cfg_data;
				REG_DIST:   accel_dist_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			upc_q        <= '0;
			begin_q      <= 1'b0;
			phase_q      <= PH_START;
			steps_done_q <= '0;
			total_q      <= '0;
			period_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q  <= 1'b1;
				upc_q   <= '0;
				begin_q <= !s_tuser;
				phase_q <= s_tuser ? phase_cls : PH_START;
			end else if (fin_go) begin
				busy_q      <= 1'b0;
				if (begin_q) begin
					total_q      <= count_q;
					steps_done_q <= '0;
					period_q     <= '0;
				end else begin
					steps_done_q <= steps_new;
					period_q     <= np;
				end
			end else if (busy_q) begin
				upc_q <= upc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= s_tdata;
		end
		if (fin_go) begin
			out_period_q <= begin_q ? 16'd0 : np[31:16];
			out_phase_q  <= phase_q;
			out_last_q   <= begin_q ? (count_q == '0) : (steps_new >= total_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_phase_q, out_period_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		steps_done_q <= total_q)
		else $error("step counter passed the movement total");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && upc_q == '0)
		else $error("accepted request did not start the sequencer");

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> upc_q <= UPC_FIN)
		else $error("sequencer ran past the last step");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy_q && upc_q == UPC_FIN))
		else $error("result appeared without a finishing step");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_stepper_ramp_period_generator.sv
`timescale 1ns / 1ps
// tb_stepper_ramp_period_generator: self-checking bench for the stepper ramp period generator.
// A directed table, then random moves under changing ramp settings, checked against a local predictor.
// Depends on srpg_pkg and stepper_ramp_period_generator.
module tb_stepper_ramp_period_generator;
	import srpg_pkg::*;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_TARGET = 2'd1;
	localparam logic [1:0] REG_ACCEL  = 2'd2;
	localparam logic [1:0] REG_DIST   = 2'd3;
	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_NEXT  = 1'b1;
	localparam int TOTAL_ITEMS     = 1650;
	localparam int DRAIN_CYCLES    = 30;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int N_ROWS          = 35;

	typedef struct packed {
		logic [15:0] period;
		phase_t      phase;
		logic        done;
	} period_res_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [55:0] reg_val;
		logic        act;
		logic [31:0] cnt;
		logic        typed;
		period_res_t want;
	} row_t;

	localparam period_res_t UNTYPED = '{16'd0, PH_START, 1'b0};

	localparam row_t DIRECTED [N_ROWS] = '{
		// next before any begin acts as a zero-step move
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'hFFFF_FFFF, 1'b1, '{16'd65535, PH_START, 1'b1}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_BEGIN, 32'd0, 1'b1, '{16'd0, PH_START, 1'b1}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_START, 1'b1}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_BEGIN, 32'hFFFF_FFFF, 1'b1, '{16'd0, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'h5A5A_5A5A, 1'b1, '{16'd65535, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'hA5A5_A5A5, 1'b1, '{16'd1000, PH_CRUISE, 1'b0}},
		// zero multiplier keeps the period at base through both ramps
		'{ROW_CFG, REG_DIST, 56'd2, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_BEGIN, 32'd5, 1'b1, '{16'd0, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_UP, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_UP, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_DOWN, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_DOWN, 1'b1}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd65535, PH_END, 1'b1}},
		// target above base, saturating multiplier
		'{ROW_CFG, REG_BASE, 56'd1, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_CFG, REG_TARGET, 56'd65535, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_CFG, REG_ACCEL, 56'hFF_FFFF_FFFF_FFFF, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_CFG, REG_DIST, 56'hFFFF_FFFF, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_BEGIN, 32'd2, 1'b1, '{16'd0, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd1, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b1, '{16'd1, PH_END, 1'b1}},
		// a plain trapezoid: up, cruise, down
		'{ROW_CFG, REG_BASE, 56'd4000, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_CFG, REG_TARGET, 56'd400, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_CFG, REG_ACCEL, 56'd200000000, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_CFG, REG_DIST, 56'd2, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_BEGIN, 32'd7, 1'b1, '{16'd0, PH_START, 1'b0}},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, REG_BASE, 56'd0, ACT_NEXT, 32'd0, 1'b0, UNTYPED}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [55:0] cfg_data;

	// predictor copy of the registers and the move state
	logic [15:0] base_us;
	logic [15:0] target_us;
	logic [55:0] accel_m;
	logic [31:0] ramp_steps;
	logic [31:0] mv_done;
	logic [31:0] mv_total;
	logic [31:0] mv_period;

	period_res_t expected_periods[$];
	int n_mismatch;
	int n_sent;
	bit tx_calm;
	bit rx_calm;

	stepper_ramp_period_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// one step of the recurrence p * (1 -/+ q + 1.5 q^2), all in 16.16 / 32.32
	function automatic logic [31:0] leib_next_period(logic [31:0] p, logic up);
		logic [127:0] p2;
		logic [127:0] q;
		logic [127:0] q2;
		logic [127:0] f;
		logic [127:0] acc;
		p2 = {96'd0, p} * {96'd0, p};
		acc = {72'd0, accel_m} * p2;
		q = {64'd0, acc[119:56]};
		q2 = (q * q) >> 32;
		f = q2 + (q2 >> 1) + (128'd1 << 32);
		if (up) begin
			f = (f < q) ? 128'd0 : f - q;
		end else begin
			f = f + q;
		end
		if (p == 32'd0) return 32'd0;
		if (f[127:64] != 64'd0) return 32'hFFFF_FFFF;
		acc = ({96'd0, p} * {64'd0, f[63:0]}) >> 32;
		if (acc[127:32] != 96'd0) return 32'hFFFF_FFFF;
		return acc[31:0];
	endfunction

	function automatic period_res_t predict_step(logic act, logic [31:0] cnt);
		period_res_t r;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] np;
		phase_t ph;
		r.period = 16'd0;
		r.phase = PH_START;
		if (act == ACT_BEGIN) begin
			mv_total = cnt;
			mv_done = 32'd0;
			mv_period = 32'd0;
		end else begin
			lo = {target_us, 16'd0};
			hi = {base_us, 16'd0};
			if (mv_done == 32'd0) ph = PH_START;
			else if (mv_done >= mv_total) ph = PH_END;
			else if (mv_done <= ramp_steps) ph = PH_UP;
			else if (mv_total - mv_done <= ramp_steps) ph = PH_DOWN;
			else ph = PH_CRUISE;
			case (ph)
				PH_START, PH_END: np = hi;
				PH_CRUISE: np = lo;
				default: begin
					np = leib_next_period(mv_period, ph == PH_UP);
					// low bound is checked first: with target above base, a period below it goes to target, any other to base
					if (np < lo) np = lo;
					else if (np > hi) np = hi;
				end
			endcase
			mv_period = np;
			r.period = np[31:16];
			r.phase = ph;
			if (mv_done < mv_total) mv_done = mv_done + 32'd1;
		end
		r.done = (mv_done >= mv_total);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want_v, input int idx);
		n_mismatch++;
		$display("result %0d: %s got %0d, expected %0d (t=%0t)", idx, field, got, want_v, $time);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [55:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BASE:   base_us = val[15:0];
			REG_TARGET: target_us = val[15:0];
			REG_ACCEL:  accel_m = val;
			REG_DIST:   ramp_steps = val[31:0];
			default: ;
		endcase
	endtask

	// registers change only with no request in flight
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (expected_periods.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_request(input logic act, input logic [31:0] cnt, input logic typed,
			input period_res_t typed_res);
		int gap;
		period_res_t r;
		if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = cnt;
		do @(posedge clk); while (!s_tready);
		r = predict_step(act, cnt);
		expected_periods.push_back(typed ? typed_res : r);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [15:0] b16;
		logic [15:0] t16;
		logic [55:0] m56;
		logic [55:0] junk;
		logic [31:0] d32;
		logic [31:0] total;
		int n_next;
		int e;
		int set_no;
		int phase_start;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 32'd0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = 56'd0;
		base_us = 16'd65535;
		target_us = 16'd1000;
		accel_m = 56'd0;
		ramp_steps = 32'd0;
		mv_done = 32'd0;
		mv_total = 32'd0;
		mv_period = 32'd0;
		n_mismatch = 0;
		n_sent = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				if (i == 0 || DIRECTED[i-1].kind != ROW_CFG) wait_idle();
				write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
			end else begin
				send_request(DIRECTED[i].act, DIRECTED[i].cnt, DIRECTED[i].typed,
					DIRECTED[i].want);
			end
		end

		set_no = 0;
		while (n_sent < TOTAL_ITEMS) begin
			wait_idle();
			junk = {$urandom, $urandom};
			case (set_no)
				0: begin
					b16 = 16'd1; t16 = 16'd1; m56 = 56'd0; d32 = 32'd0;
				end
				1: begin
					b16 = '1; t16 = '1; m56 = '1; d32 = '1;
				end
				2: begin
					b16 = '1; t16 = 16'd1; m56 = '1; d32 = 32'd3;
				end
				default: begin
					b16 = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(200, 65535));
					if ($urandom_range(0, 7) == 0) t16 = 16'($urandom_range(1, 65535));
					else t16 = 16'($urandom_range(1, b16));
					// mostly a multiplier that gives q of about 1 to 3 times 2^-e at base, e from 2 to 14
					e = $urandom_range(2, 14);
					if ($urandom_range(0, 3) == 0)
						m56 = 56'({$urandom, $urandom}) >> $urandom_range(0, 55);
					else
						m56 = 56'(((64'd1 << (56 - e)) / (64'(b16) * 64'(b16)))
							* $urandom_range(1, 3)) + 56'($urandom_range(0, 255));
					case ($urandom_range(0, 7))
						0: d32 = '1;
						1: d32 = 32'd0;
						default: d32 = 32'($urandom_range(1, 25));
					endcase
				end
			endcase
			// junk in the unused upper bits must be dropped
			write_reg(REG_BASE, {junk[55:16], b16});
			write_reg(REG_TARGET, {~junk[55:16], t16});
			write_reg(REG_ACCEL, m56);
			write_reg(REG_DIST, {junk[55:32], d32});
			set_no++;

			phase_start = n_sent;
			while (n_sent - phase_start < 120 && n_sent < TOTAL_ITEMS) begin
				case ($urandom_range(0, 7))
					0: total = $urandom;
					1: total = 32'd0;
					default: begin
						if (d32 > 40) total = 32'($urandom_range(1, 60));
						else total = 32'($urandom_range(1, 2 * d32 + 12));
					end
				endcase
				send_request(ACT_BEGIN, total, 1'b0, UNTYPED);
				if (total > 200) n_next = $urandom_range(1, 40);
				else if ($urandom_range(0, 4) == 0) n_next = $urandom_range(0, total);
				else n_next = total + $urandom_range(1, 3);
				repeat (n_next) begin
					if ($urandom_range(0, 19) == 0)
						send_request(1'($urandom_range(0, 1)), $urandom, 1'b0, UNTYPED);
					else
						send_request(ACT_NEXT, $urandom, 1'b0, UNTYPED);
				end
			end
		end

		wait_idle();
		if (n_mismatch == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : result_sink
		period_res_t want;
		int stall;
		int n_taken;
		n_taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 19);
			// long hold-off so the block backs up into its input
			if (n_taken == 200 || n_taken == 900) stall = HOLD_OFF_CYCLES;
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_periods.size() == 0) begin
				report_mismatch("unexpected result", {8'd0, m_tdata}, 32'd0, n_taken);
			end else begin
				want = expected_periods.pop_front();
				if (m_tdata[15:0] !== want.period)
					report_mismatch("period_us", 32'(m_tdata[15:0]), 32'(want.period), n_taken);
				if (m_tdata[18:16] !== want.phase)
					report_mismatch("phase", 32'(m_tdata[18:16]), 32'(want.phase), n_taken);
				if (m_tlast !== want.done)
					report_mismatch("done", 32'(m_tlast), 32'(want.done), n_taken);
			end
			n_taken++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
